// ===== hw/rtl/sfh_pkg.sv =====
`default_nettype none
package sfh_pkg;

   localparam int unsigned HashWidth     = 32;
   localparam int unsigned CountWidth    = 3;
   localparam int unsigned QueueDepth    = 2;
   localparam int unsigned QueuePtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [CountWidth-1:0] CountOne   = 3'd1;
   localparam logic [CountWidth-1:0] CountTwo   = 3'd2;
   localparam logic [CountWidth-1:0] CountThree = 3'd3;
   localparam logic [CountWidth-1:0] CountFull  = 3'd4;

   typedef logic [HashWidth-1:0] hash_type;

   // per-word update: add low half, fold in high half, then self-add
   function automatic hash_type mix_full_word(input hash_type h_arg, input hash_type w_arg);
      hash_type h;
      hash_type t;
      h = h_arg + {16'd0, w_arg[15:0]};
      t = {5'd0, w_arg[31:16], 11'd0} ^ h;
      h = {h[15:0], 16'd0} ^ t;
      h = h + {11'd0, h[31:11]};
      return h;
   endfunction

   function automatic hash_type mix_tail(input hash_type h_arg, input hash_type w_arg,
                                         input logic [CountWidth-1:0] n_arg);
      hash_type h;
      h = h_arg;
      case (n_arg)
         CountThree: begin
            h = h + {16'd0, w_arg[15:0]};
            h = h ^ {h[15:0], 16'd0};
            h = h ^ {6'd0, w_arg[23:16], 18'd0};
            h = h + {11'd0, h[31:11]};
         end
         CountTwo: begin
            h = h + {16'd0, w_arg[15:0]};
            h = h ^ {h[20:0], 11'd0};
            h = h + {17'd0, h[31:17]};
         end
         CountOne: begin
            h = h + {24'd0, w_arg[7:0]};
            h = h ^ {h[21:0], 10'd0};
            h = h + {1'b0, h[31:1]};
         end
         default: h = h_arg;
      endcase
      return h;
   endfunction

   function automatic hash_type avalanche(input hash_type h_arg);
      hash_type h;
      h = h_arg;
      h = h ^ {h[28:0], 3'd0};
      h = h + {5'd0, h[31:5]};
      h = h ^ {h[29:0], 2'd0};
      h = h + {15'd0, h[31:15]};
      h = h ^ {h[21:0], 10'd0};
      return h;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/super_fast_hash_stream.sv =====
`default_nettype none
// a final word's hash is written into the queue, then mixed and registered in the output stage before it shows on rsp_
// throughput: one word per cycle while the queue is not full; the running-hash update in the front stage is the loop
// a two-entry queue lets the front keep taking words while the result side stalls
// reset (synchronous, active high) clears the running hash, the queue and the output
module super_fast_hash_stream (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [31:0]                       req_word_bytes,
   input  wire logic [sfh_pkg::CountWidth-1:0]    req_byte_count,
   input  wire logic                              req_last_word,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [31:0]                            rsp_hash_value
);

   logic              accept;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   sfh_pkg::hash_type q_wdata;
   sfh_pkg::hash_type q_rdata;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   sfh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .word_bytes (req_word_bytes),
      .byte_count (req_byte_count),
      .last_word  (req_last_word),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   sfh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   sfh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_hash  (rsp_hash_value)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/sfh_front.sv =====
`default_nettype none
module sfh_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [31:0]                       word_bytes,
   input  wire logic [sfh_pkg::CountWidth-1:0]    byte_count,
   input  wire logic                              last_word,
   output logic                                   q_push,
   output sfh_pkg::hash_type                      q_data
);

   sfh_pkg::hash_type running_hash_ff;
   sfh_pkg::hash_type running_hash_in;
   sfh_pkg::hash_type full_mix;

   assign full_mix = sfh_pkg::mix_full_word(running_hash_ff, word_bytes);

   always_comb begin
      running_hash_in = running_hash_ff;
      q_push          = 1'b0;
      q_data          = full_mix;
      if (accept) begin
         if (last_word) begin
            // counts of four and above take the full-word step
            if (byte_count < sfh_pkg::CountFull) begin
               q_data = sfh_pkg::mix_tail(running_hash_ff, word_bytes, byte_count);
            end
            q_push          = 1'b1;
            running_hash_in = '0;
         end else begin
            running_hash_in = full_mix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sfh_queue.sv =====
`default_nettype none
module sfh_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfh_pkg::hash_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output sfh_pkg::hash_type      pop_data,
   output logic                   empty
);

   sfh_pkg::hash_type                    mem_ff [sfh_pkg::QueueDepth];
   logic [sfh_pkg::QueuePtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sfh_pkg::QueuePtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sfh_pkg::QueueCntWidth-1:0]    count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign full     = (count_ff == sfh_pkg::QueueCntWidth'(sfh_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   function automatic logic [sfh_pkg::QueuePtrWidth-1:0] ptr_next(
         input logic [sfh_pkg::QueuePtrWidth-1:0] p);
      logic [sfh_pkg::QueuePtrWidth-1:0] r;
      if (p == sfh_pkg::QueuePtrWidth'(sfh_pkg::QueueDepth - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sfh_pkg::QueueCntWidth'(sfh_pkg::QueueDepth))
      else $error("queue count beyond depth");

   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after a push");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

// ===== hw/rtl/sfh_back.sv =====
`default_nettype none
module sfh_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire sfh_pkg::hash_type q_data,
   output logic                   q_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output sfh_pkg::hash_type      rsp_hash
);

   logic              out_valid_ff, out_valid_in;
   sfh_pkg::hash_type out_hash_ff;

   // refill the output register when it is free or being drained
   assign q_pop        = !q_empty && (!out_valid_ff || rsp_pop);
   assign out_valid_in = q_pop || (out_valid_ff && !rsp_pop);
   assign rsp_empty    = !out_valid_ff;
   assign rsp_hash     = out_hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_hash_ff <= sfh_pkg::avalanche(q_data);
      end
   end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [31:0] req_word_bytes = '0;
   logic [sfh_pkg::CountWidth-1:0] req_byte_count = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_hash_value;

   logic [31:0] expected_hashes[$];
   logic [31:0] running_hash = '0;
   int unsigned send_idle_pct = 0;
   int unsigned pop_idle_pct = 0;
   int unsigned words_sent = 0;
   int unsigned mismatch_count = 0;

   super_fast_hash_stream uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_word_bytes(req_word_bytes),
      .req_byte_count(req_byte_count),
      .req_last_word (req_last_word),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_hash_value(rsp_hash_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [31:0] word_round(input logic [31:0] h, input logic [31:0] w);
      logic [31:0] t;
      h = h + {16'd0, w[15:0]};
      t = ({16'd0, w[31:16]} << 11) ^ h;
      h = (h << 16) ^ t;
      h = h + (h >> 11);
      return h;
   endfunction

   function automatic logic [31:0] tail_round(input logic [31:0] h, input logic [31:0] w,
                                              input logic [sfh_pkg::CountWidth-1:0] n);
      case (n)
         sfh_pkg::CountThree: begin
            h = h + {16'd0, w[15:0]};
            h = h ^ (h << 16);
            h = h ^ ({24'd0, w[23:16]} << 18);
            h = h + (h >> 11);
         end
         sfh_pkg::CountTwo: begin
            h = h + {16'd0, w[15:0]};
            h = h ^ (h << 11);
            h = h + (h >> 17);
         end
         sfh_pkg::CountOne: begin
            h = h + {24'd0, w[7:0]};
            h = h ^ (h << 10);
            h = h + (h >> 1);
         end
         default: begin
         end
      endcase
      return h;
   endfunction

   function automatic logic [31:0] final_mix(input logic [31:0] h);
      h = h ^ (h << 3);
      h = h + (h >> 5);
      h = h ^ (h << 2);
      h = h + (h >> 15);
      h = h ^ (h << 10);
      return h;
   endfunction

   // the count only matters on the last word, and saturates at a full word
   task automatic predict_word(input logic [31:0] w, input logic [sfh_pkg::CountWidth-1:0] n,
                               input logic l);
      logic [31:0] h;
      if (!l) begin
         running_hash = word_round(running_hash, w);
      end else begin
         if (n >= sfh_pkg::CountFull) h = word_round(running_hash, w);
         else h = tail_round(running_hash, w, n);
         expected_hashes.push_back(final_mix(h));
         running_hash = '0;
      end
   endtask

   task automatic send_word(input logic [31:0] w, input logic [sfh_pkg::CountWidth-1:0] n,
                            input logic l);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_word_bytes <= w;
      req_byte_count <= n;
      req_last_word  <= l;
      do @(posedge clock); while (req_full);
      predict_word(w, n, l);
      words_sent++;
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_hashes.size() != 0) @(posedge clock);
   endtask

   // full words are well formed; noisy messages put junk counts on non-final words
   task automatic send_message(input int unsigned n_words, input bit noisy);
      logic [sfh_pkg::CountWidth-1:0] n;
      for (int unsigned i = 1; i < n_words; i++) begin
         n = noisy ? sfh_pkg::CountWidth'($urandom_range(7)) : sfh_pkg::CountFull;
         send_word($urandom, n, 1'b0);
      end
      if ($urandom_range(9) < 8) n = sfh_pkg::CountWidth'($urandom_range(4));
      else n = sfh_pkg::CountWidth'($urandom_range(7, 5));
      send_word($urandom, n, 1'b1);
   endtask

   task automatic test_directed();
      // empty message straight after reset and again after a message
      send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
      send_word(32'h0000_0000, sfh_pkg::CountOne, 1'b1);
      send_word(32'hFFFF_FFFF, sfh_pkg::CountOne, 1'b1);
      send_word(32'hFFFF_FF80, sfh_pkg::CountOne, 1'b1);
      send_word(32'hFFFF_8080, sfh_pkg::CountTwo, 1'b1);
      send_word(32'h0000_FFFF, sfh_pkg::CountTwo, 1'b1);
      send_word(32'hFF80_8080, sfh_pkg::CountThree, 1'b1);
      send_word(32'h00FF_FFFF, sfh_pkg::CountThree, 1'b1);
      send_word(32'hFFFF_FFFF, sfh_pkg::CountFull, 1'b1);
      send_word(32'h0000_0000, sfh_pkg::CountFull, 1'b1);
      send_word(32'h0000_0000, 3'd0, 1'b1);
      // counts above four on the last word
      send_word(32'h8000_0001, 3'd5, 1'b1);
      send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
      // counts on non-final words are ignored
      send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
      send_word(32'h8000_0000, 3'd7, 1'b0);
      send_word(32'h0000_0001, sfh_pkg::CountOne, 1'b0);
      send_word(32'h1234_5678, sfh_pkg::CountThree, 1'b1);
      send_word(32'hFFFF_FFFF, sfh_pkg::CountFull, 1'b0);
      send_word(32'hFFFF_FFFF, sfh_pkg::CountFull, 1'b0);
      send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
      send_word(32'hDEAD_BEEF, sfh_pkg::CountFull, 1'b0);
      send_word(32'hFFFF_FFFF, sfh_pkg::CountTwo, 1'b1);
      wait_for_drain();
   endtask

   task automatic test_random(input int unsigned n_items);
      int unsigned target;
      int unsigned len;
      target = words_sent + n_items;
      while (words_sent < target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
         send_message(len, $urandom_range(9) == 0);
      end
      wait_for_drain();
   endtask

   // sender holds off until every hash is out, then carries on mid-stream
   task automatic test_drain_pause();
      for (int i = 0; i < 6; i++) send_message($urandom_range(5, 1), 1'b0);
      wait_for_drain();
      send_word($urandom, sfh_pkg::CountFull, 1'b0);
      wait_for_drain();
      send_word($urandom, sfh_pkg::CountThree, 1'b1);
      wait_for_drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_hashes.size() == 0) begin
               $display("%0t: unexpected hash, expected none, actual %h", $time,
                        rsp_hash_value);
               mismatch_count++;
            end else if (rsp_hash_value !== expected_hashes[0]) begin
               $display("%0t: hash mismatch, expected %h, actual %h", $time,
                        expected_hashes[0], rsp_hash_value);
               mismatch_count++;
               void'(expected_hashes.pop_front());
            end else begin
               void'(expected_hashes.pop_front());
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      pop_idle_pct  = 81;
      test_directed();
      test_random(570);

      send_idle_pct = 81;
      pop_idle_pct  = 29;
      test_drain_pause();
      test_random(570);

      send_idle_pct = 0;
      pop_idle_pct  = 0;
      test_random(570);

      req_push <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
